// ----- hdl/mtbsc_pkg.sv -----
package mtbsc_pkg;

	// generator geometry
	localparam int STATE_WORDS_DEF = 624;
	localparam int TW_SHIFT        = 397;

	// twist, tempering and seeding constants
	localparam logic [31:0] TW_MATRIX    = 32'h9908_B0DF;
	localparam logic [31:0] TW_UPPER     = 32'h8000_0000;
	localparam logic [31:0] TW_LOWER     = 32'h7FFF_FFFF;
	localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
	localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;
	localparam logic [31:0] LCG_MULT     = 32'd69069;
	localparam logic [31:0] HALF_MASK    = 32'hFFFF_0000;
	localparam logic [31:0] DEFAULT_SEED = 32'h0000_1105;

	// stream payload widths
	localparam int SEED_W = 32;
	localparam int BYTE_W = 8;
	localparam int S_DATA_W = 40;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED_HI,
		ST_SEED_LO,
		ST_REGEN_PRE,
		ST_REGEN_LOAD,
		ST_REGEN_RD,
		ST_REGEN_WR,
		ST_FETCH,
		ST_DELIVER
	} state_t;

	// output tempering of one table word
	function automatic logic [31:0] temper(input logic [31:0] x);
		logic [31:0] v;
		v = x;
		v = v ^ (v >> 11);
		v = v ^ ((v << 7) & TEMPER_B);
		v = v ^ ((v << 15) & TEMPER_C);
		v = v ^ (v >> 18);
		return v;
	endfunction

	// one step of the twist recurrence
	function automatic logic [31:0] twist(input logic [31:0] upper_src,
			input logic [31:0] lower_src, input logic [31:0] far);
		logic [31:0] y;
		y = (upper_src & TW_UPPER) | (lower_src & TW_LOWER);
		return far ^ (y >> 1) ^ (y[0] ? TW_MATRIX : 32'd0);
	endfunction

endpackage

// ----- hdl/mt19937_byte_stream_cipher_top.sv -----
// with an unused word in the table, an accepted word goes through ST_DELIVER to the output register
// a new word is taken only after the current one has left ST_DELIVER
// table regeneration runs once every STATE_WORDS words (one twist per REGEN_RD and REGEN_WR pair)
// reseeding runs ahead of the regeneration it forces (two 69069 steps per word)
// reset clears the sequencer, the output valid and marks the generator unseeded
// the table itself is not cleared by reset; seeding always writes it before use
module mt19937_byte_stream_cipher_top
	import mtbsc_pkg::*;
#(
	parameter int STATE_WORDS = STATE_WORDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // seed [31:0], data_in [39:32]
	input  logic                s_tuser,  // first [0]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [BYTE_W-1:0]   m_tdata   // data_out [7:0]
);

	localparam int IDX_W = $clog2(STATE_WORDS);
	localparam int POS_W = $clog2(STATE_WORDS + 2);
	localparam int SPLIT = STATE_WORDS - TW_SHIFT;
	localparam logic [POS_W-1:0] POS_FULL  = POS_W'(STATE_WORDS);
	localparam logic [POS_W-1:0] POS_NEVER = POS_W'(STATE_WORDS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(STATE_WORDS - 1);
	localparam logic [IDX_W-1:0] SPLIT_IDX = IDX_W'(SPLIT);
	localparam logic [IDX_W-1:0] SHIFT_IDX = IDX_W'(TW_SHIFT);

	state_t             state_q, state_d;
	logic [POS_W-1:0]   pos_q;
	logic [IDX_W-1:0]   k_q;
	logic [31:0]        w_q, hi_q, cur_q;
	logic [BYTE_W-1:0]  data_q;
	logic [31:0]        rd_a_q, rd_b_q;
	logic               m_tvalid_q;
	logic [BYTE_W-1:0]  m_tdata_q;
	logic [31:0]        mem [STATE_WORDS];

	logic [IDX_W-1:0]   addr_a, addr_b, waddr;
	logic               we;
	logic [31:0]        wdata;
	logic [31:0]        lcg_next;
	logic [31:0]        tempered;
	logic               s_fire, deliver_fire, k_last;
	logic [IDX_W-1:0]   k_next;

	assign s_tready     = (state_q == ST_IDLE);
	assign s_fire       = s_tvalid && s_tready;
	assign deliver_fire = (state_q == ST_DELIVER) && (!m_tvalid_q || m_tready);
	assign m_tvalid     = m_tvalid_q;
	assign m_tdata      = m_tdata_q;
	assign k_last       = (k_q == LAST_IDX);
	assign k_next       = k_last ? '0 : k_q + IDX_W'(1);

	// shared lcg multiplier, one step per cycle
	assign lcg_next = w_q * LCG_MULT + 32'd1;
	assign tempered = temper(rd_a_q);

	// sequencer next state and memory port control
	always_comb begin
		state_d = state_q;
		addr_a  = pos_q[IDX_W-1:0];
		addr_b  = '0;
		we      = 1'b0;
		waddr   = k_q;
		wdata   = hi_q | {16'd0, w_q[31:16]};
		case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					if (s_tuser || pos_q == POS_NEVER)
						state_d = ST_SEED_HI;
					else if (pos_q == POS_FULL)
						state_d = ST_REGEN_PRE;
					else
						state_d = ST_DELIVER;
				end
			end
			ST_SEED_HI: begin
				state_d = ST_SEED_LO;
			end
			ST_SEED_LO: begin
				we      = 1'b1;
				state_d = k_last ? ST_REGEN_PRE : ST_SEED_HI;
			end
			ST_REGEN_PRE: begin
				addr_a  = '0;
				state_d = ST_REGEN_LOAD;
			end
			ST_REGEN_LOAD: begin
				state_d = ST_REGEN_RD;
			end
			ST_REGEN_RD: begin
				addr_a  = k_next;
				addr_b  = (k_q < SPLIT_IDX) ? k_q + SHIFT_IDX : k_q - SPLIT_IDX;
				state_d = ST_REGEN_WR;
			end
			ST_REGEN_WR: begin
				we      = 1'b1;
				wdata   = twist(cur_q, rd_a_q, rd_b_q);
				state_d = k_last ? ST_FETCH : ST_REGEN_RD;
			end
			ST_FETCH: begin
				state_d = ST_DELIVER;
			end
			ST_DELIVER: begin
				if (deliver_fire)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer state and word position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= POS_NEVER;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SEED_LO && k_last)
				pos_q <= POS_FULL;
			else if (state_q == ST_REGEN_WR && k_last)
				pos_q <= '0;
			else if (deliver_fire)
				pos_q <= pos_q + POS_W'(1);
		end
	end

	// seeding, twist and input word datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					data_q <= s_tdata[SEED_W +: BYTE_W];
					w_q    <= s_tuser ? s_tdata[SEED_W-1:0] : DEFAULT_SEED;
					k_q    <= '0;
				end
			end
			ST_SEED_HI: begin
				hi_q <= w_q & HALF_MASK;
				w_q  <= lcg_next;
			end
			ST_SEED_LO: begin
				w_q <= lcg_next;
				k_q <= k_next;
			end
			ST_REGEN_LOAD: begin
				cur_q <= rd_a_q;
			end
			ST_REGEN_WR: begin
				cur_q <= rd_a_q;
				k_q   <= k_next;
			end
			default: begin
			end
		endcase
	end

	// state table: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_a_q <= mem[addr_a];
		rd_b_q <= mem[addr_b];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (deliver_fire)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (deliver_fire)
			m_tdata_q <= data_q ^ tempered[BYTE_W-1:0];
	end

endmodule

// ----- hdl/mtbsc_checker.sv -----
module mtbsc_checker
	import mtbsc_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [BYTE_W-1:0]   m_tdata   // data_out [7:0]
);

	logic [2:0] pending_q;
	logic       s_acc, m_acc;

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;

	// words taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pending_q <= '0;
		else if (s_acc && !m_acc)
			pending_q <= pending_q + 3'd1;
		else if (m_acc && !s_acc)
			pending_q <= pending_q - 3'd1;
	end

	// a waiting result holds its word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	// an accepted word leaves the block busy, with s_tready low, after the accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !s_tready)
		else $error("input accepted on consecutive cycles");

	// at most one word in work plus one waiting in the output register
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd2)
		else $error("too many words in flight");

	// no result without a word taken in
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 3'd0 |-> !m_tvalid)
		else $error("result with no word pending");

endmodule

bind mt19937_byte_stream_cipher_top mtbsc_checker u_mtbsc_checker (.*);

// ----- tb/sv/mt19937_byte_stream_cipher_top_test.sv -----
`timescale 1ns / 1ps

module mt19937_byte_stream_cipher_top_test;
	import mtbsc_pkg::*;

	// idling profiles of the stimulus phases
	typedef enum int {
		PH_STEADY,
		PH_SEND_GAPS,
		PH_RECV_STALLS,
		PH_BOTH
	} idle_mode_t;

	localparam int NEVER_SEEDED  = STATE_WORDS_DEF + 1;
	localparam int RANDOM_BYTES  = 720;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_CYCLES  = 16;

	// keystream predictor and queue of expected cipher bytes
	class keystream_scoreboard;
		bit [31:0] mt_words[STATE_WORDS_DEF];
		int        word_pos;
		bit [7:0]  expected_bytes[$];
		int        errors;

		function new();
			word_pos = NEVER_SEEDED;
			errors = 0;
		endfunction

		// 69069 lcg fill, two steps per table word
		function void reseed(input bit [31:0] s);
			bit [31:0] w;
			bit [31:0] hi;
			w = s;
			for (int i = 0; i < STATE_WORDS_DEF; i++) begin
				hi = w & HALF_MASK;
				w = w * LCG_MULT + 32'd1;
				mt_words[i] = hi | ((w & HALF_MASK) >> 16);
				w = w * LCG_MULT + 32'd1;
			end
			word_pos = STATE_WORDS_DEF;
		endfunction

		function void note_input(input bit first, input bit [31:0] seed, input bit [7:0] data);
			bit [31:0] y;
			bit [31:0] v;
			if (first)
				reseed(seed);
			// table used up or never seeded: regenerate in place
			if (word_pos >= STATE_WORDS_DEF) begin
				if (word_pos != STATE_WORDS_DEF)
					reseed(DEFAULT_SEED);
				for (int k = 0; k < STATE_WORDS_DEF; k++) begin
					y = (mt_words[k] & TW_UPPER) |
						(mt_words[(k + 1) % STATE_WORDS_DEF] & TW_LOWER);
					mt_words[k] = mt_words[(k + TW_SHIFT) % STATE_WORDS_DEF] ^ (y >> 1) ^
						(y[0] ? TW_MATRIX : 32'd0);
				end
				word_pos = 0;
			end
			// tempering of the next word
			v = mt_words[word_pos];
			word_pos++;
			v = v ^ (v >> 11);
			v = v ^ ((v << 7) & TEMPER_B);
			v = v ^ ((v << 15) & TEMPER_C);
			v = v ^ (v >> 18);
			expected_bytes.push_back(data ^ v[7:0]);
		endfunction

		function void check_result(input bit [7:0] got);
			bit [7:0] want;
			if (expected_bytes.size() == 0) begin
				$error("data_out: unexpected word, expected none, actual %02h", got);
				errors++;
			end else begin
				want = expected_bytes.pop_front();
				if (got !== want) begin
					$error("data_out: expected %02h, actual %02h", want, got);
					errors++;
				end
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic                s_tuser = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [BYTE_W-1:0]   m_tdata;

	keystream_scoreboard sb = new();
	idle_mode_t          idle_mode = PH_STEADY;
	bit                  hold_req = 1'b0;
	bit [31:0]           byte_count = '0;

	mt19937_byte_stream_cipher_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// offer one byte, with optional idle cycles ahead of it
	task automatic send_byte(input bit first, input bit [31:0] seed, input bit [7:0] data);
		int gap_pct;
		gap_pct = (idle_mode == PH_SEND_GAPS) ? 52 : (idle_mode == PH_BOTH) ? 38 : 0;
		if ($urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < gap_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= first;
		s_tdata  <= {data, seed};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_input(first, seed, data);
		byte_count++;
	endtask

	// receiver: check results, stall at random, long hold-off on request
	initial begin
		int hold_left;
		int stall_pct;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			stall_pct = (idle_mode == PH_RECV_STALLS) ? 52 : (idle_mode == PH_BOTH) ? 38 : 0;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// stimulus
	initial begin
		int        sent;
		int        frame_len;
		bit [31:0] frame_seed;
		bit        frame_first;
		bit        first;
		bit [31:0] seed;
		sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bytes before any seeding use the default seed
		send_byte(1'b0, 32'hFFFF_FFFF, 8'h00);
		send_byte(1'b0, 32'h0000_0000, 8'hFF);
		// seed extremes, back-to-back reseeds
		send_byte(1'b1, 32'h0000_0000, 8'h5A);
		send_byte(1'b1, 32'hFFFF_FFFF, 8'hA5);
		send_byte(1'b0, 32'h1234_5678, 8'h00);
		send_byte(1'b1, 32'h0000_0001, 8'hFF);
		send_byte(1'b1, 32'h8000_0000, 8'h3C);
		send_byte(1'b0, 32'h0000_0000, 8'h81);
		send_byte(1'b1, DEFAULT_SEED, 8'h7E);
		send_byte(1'b0, 32'hFFFF_FFFF, 8'h01);
		send_byte(1'b0, 32'h0000_0000, 8'hFE);
		send_byte(1'b1, byte_count, 8'h10);
		send_byte(1'b0, 32'h5555_AAAA, 8'hEF);

		// random frames: mostly well-formed byte-count seeds, some long enough to regenerate
		while (sent < RANDOM_BYTES) begin
			if ($urandom_range(0, 5) == 0)
				frame_len = $urandom_range(620, 700);
			else
				frame_len = $urandom_range(8, 40);
			frame_first = ($urandom_range(0, 7) != 0);
			frame_seed = ($urandom_range(0, 3) != 0) ? byte_count : $urandom;
			for (int i = 0; i < frame_len && sent < RANDOM_BYTES; i++) begin
				idle_mode = idle_mode_t'((sent * 4) / RANDOM_BYTES);
				if (sent == 60)
					hold_req = 1'b1;
				first = (i == 0) ? frame_first : ($urandom_range(0, 63) == 0);
				seed = (i == 0) ? frame_seed : $urandom;
				send_byte(first, seed, 8'($urandom_range(0, 255)));
				sent++;
			end
		end
		s_tvalid <= 1'b0;

		// drain
		while (sb.expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.expected_bytes.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule
